[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the sorted priority stack.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
    localparam int STATUS_BITS   = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic                     operation;
        logic [VALUE_BITS-1:0]    item_value;
        logic [PRIORITY_BITS-1:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    front_value;
        logic [PRIORITY_BITS-1:0] front_priority;
        logic [COUNT_BITS-1:0]    entry_count;
        logic                     is_empty;
        logic [STATUS_BITS-1:0]   status;
    } t_out_result;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_dp_cmd;

endpackage

[rtl/sps_ctrl.sv]
// ----------------------------------------------------------------------------
// sps_ctrl
// Controller: takes one transaction, runs it through the datapath, and keeps
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sps_pkg::t_dp_cmd o_cmd
);

    sps_pkg::t_state r_state;
    sps_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sps_pkg::ST_EXEC;
                end
            end
            sps_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = sps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            sps_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            sps_pkg::ST_EXEC: begin
                o_cmd.exec = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sps_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/sps_datapath.sv]
// ----------------------------------------------------------------------------
// sps_datapath
// Row of sorted entry cells with parallel compare, the entry count, the
// input holding register and the result register.
// ----------------------------------------------------------------------------
module sps_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sps_pkg::t_dp_cmd     i_cmd,
    input  sps_pkg::t_in_item    i_item,
    output sps_pkg::t_out_result o_result
);

    localparam int CAPACITY = sps_pkg::CAPACITY;
    localparam int CNT_W    = sps_pkg::COUNT_BITS;

    logic [sps_pkg::VALUE_BITS-1:0]    r_val [CAPACITY];
    logic [sps_pkg::PRIORITY_BITS-1:0] r_pri [CAPACITY];
    logic [sps_pkg::VALUE_BITS-1:0]    n_val [CAPACITY];
    logic [sps_pkg::PRIORITY_BITS-1:0] n_pri [CAPACITY];
    logic [CNT_W-1:0]                  r_count;
    logic [CNT_W-1:0]                  n_count;
    sps_pkg::t_in_item                 r_item;
    sps_pkg::t_out_result              r_result;
    sps_pkg::t_out_result              n_result;

    logic [CAPACITY-1:0] stays;
    logic [CAPACITY-1:0] prev_stays;
    logic                full;
    logic                empty;
    logic                do_push;
    logic                do_pop;

    always_comb begin
        full    = r_count == CNT_W'(CAPACITY);
        empty   = r_count == '0;
        do_push = (r_item.operation == sps_pkg::OP_PUSH) && !full;
        do_pop  = (r_item.operation == sps_pkg::OP_POP) && !empty;

        for (int k = 0; k < CAPACITY; k++) begin
            stays[k] = (CNT_W'(k) < r_count) && (r_item.item_priority < r_pri[k]);
        end
        prev_stays[0] = 1'b1;
        for (int k = 1; k < CAPACITY; k++) begin
            prev_stays[k] = stays[k-1];
        end

        for (int k = 0; k < CAPACITY; k++) begin
            n_val[k] = r_val[k];
            n_pri[k] = r_pri[k];
        end

        if (do_push) begin
            for (int k = 0; k < CAPACITY; k++) begin
                if (!stays[k] && prev_stays[k]) begin
                    n_val[k] = r_item.item_value;
                    n_pri[k] = r_item.item_priority;
                end
            end
            for (int k = 1; k < CAPACITY; k++) begin
                if (!stays[k] && !prev_stays[k]) begin
                    n_val[k] = r_val[k-1];
                    n_pri[k] = r_pri[k-1];
                end
            end
        end else if (do_pop) begin
            for (int k = 0; k < CAPACITY - 1; k++) begin
                n_val[k] = r_val[k+1];
                n_pri[k] = r_pri[k+1];
            end
        end

        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end

        if (n_count != '0) begin
            n_result.front_value    = n_val[0];
            n_result.front_priority = n_pri[0];
            n_result.is_empty       = 1'b0;
        end else begin
            n_result.front_value    = '0;
            n_result.front_priority = '0;
            n_result.is_empty       = 1'b1;
        end
        n_result.entry_count = n_count;

        if (r_item.operation == sps_pkg::OP_PUSH && full) begin
            n_result.status = sps_pkg::STATUS_PUSH_FULL;
        end else if (r_item.operation == sps_pkg::OP_POP && empty) begin
            n_result.status = sps_pkg::STATUS_POP_EMPTY;
        end else begin
            n_result.status = sps_pkg::STATUS_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
            for (int k = 0; k < CAPACITY; k++) begin
                r_val[k] <= n_val[k];
                r_pri[k] <= n_pri[k];
            end
        end
    end

    assign o_result = r_result;

endmodule

[rtl/sorted_priority_stack_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_stack_core
// Flow: an accepted transaction's item is captured in the input register and
// its result is registered in the execute state, which waits while the
// previous result still waits to be taken. No new transaction is accepted
// until the controller is back in idle; all cells compare and shift in the execute state.
// Reset: synchronous, active low; empties the stack and clears the output valid.
// ----------------------------------------------------------------------------
module sorted_priority_stack_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sps_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sps_pkg::t_out_result o_out_result
);

    sps_pkg::t_dp_cmd cmd;

    sps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sps_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_item),
        .o_result (o_out_result)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input accepted while a transaction was in progress.");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_result.is_empty == (o_out_result.entry_count == '0)))
        else $error("Empty flag disagrees with the entry count.");

    a_pop_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_result.status == sps_pkg::STATUS_POP_EMPTY)
        |-> o_out_result.is_empty)
        else $error("Pop on empty reported while entries are held.");

    a_push_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_result.status == sps_pkg::STATUS_PUSH_FULL)
        |-> (o_out_result.entry_count == sps_pkg::COUNT_BITS'(sps_pkg::CAPACITY)))
        else $error("Push on full reported below capacity.");
`endif

endmodule
